FILE: rtl/accel_sample_health_monitor_macros.svh
// Assertion macros used by the health monitor top level.
`ifndef ACCEL_SAMPLE_HEALTH_MONITOR_MACROS_SVH
`define ACCEL_SAMPLE_HEALTH_MONITOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASHM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("health monitor assertion failed");
// Check a property on every clock edge, reset included.
`define ASHM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("health monitor assertion failed");
`else
`define ASHM_ASSERT(label, clk, rst, prop)
`define ASHM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/ashm_pkg.sv
// Shared types and constants of the accel sample health monitor.
package ashm_pkg;

  localparam int SLOT_W        = 3;
  localparam int NUM_CFG       = 8;
  localparam int CFG_W         = 8;
  localparam int NUM_SLOTS_DEF = 8;
  localparam int WAIT_W        = 5;
  localparam int RUN_W         = 7;
  localparam int AXIS_W        = 16;
  localparam int NUM_AXES      = 3;
  localparam int TOTAL_W       = 32;
  localparam int NEW_XYZ_BIT   = 3;

  localparam logic [WAIT_W-1:0] WAIT_TICKS    = WAIT_W'(20);
  localparam logic [RUN_W-1:0]  STUCK_LIMIT   = RUN_W'(100);
  localparam logic [SLOT_W-1:0] IDENTITY_SLOT = '0;

  localparam logic [CFG_W-1:0] EXPECTED_RESET [NUM_CFG] = '{
    8'd73, 8'd159, 8'd224, 8'd4, 8'd4, 8'd244, 8'd0, 8'd0
  };

  typedef enum logic [1:0] {
    ST_PUBLISH = 2'd0,
    ST_WAIT    = 2'd1,
    ST_NO_DATA = 2'd2,
    ST_STUCK   = 2'd3
  } sample_status_t;

  // Register check outcome for the item at the input.
  typedef struct packed {
    logic                mismatch;
    logic                wait_active;
    logic                rewrite_request;
    logic [SLOT_W-1:0]   rewrite_slot;
    logic [CFG_W-1:0]    rewrite_value;
    logic [SLOT_W-1:0]   next_slot;
  } chk_t;

endpackage

FILE: rtl/ashm_axis_lane.sv
// One axis lane: holds the last published sample and compares the new one.
module ashm_axis_lane
  import ashm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [AXIS_W-1:0] sample,
  input  logic                     load,
  output logic                     match
);

  logic signed [AXIS_W-1:0] last_sample;

  assign match = (sample == last_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= '0;
    end else if (load) begin
      last_sample <= sample;
    end
  end

endmodule

FILE: rtl/ashm_reg_check.sv
// Round-robin register check, expected values and recovery wait.
module ashm_reg_check
  import ashm_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [CFG_W-1:0]  reg_readback,
  input  logic              advance,
  output chk_t              chk
);

  logic [CFG_W-1:0]  expected [NUM_CFG];
  logic [SLOT_W-1:0] check_slot;
  logic [WAIT_W-1:0] recovery_wait;
  logic [CFG_W-1:0]  exp_sel;
  logic [WAIT_W-1:0] wait_cur;
  logic [SLOT_W:0]   slot_inc;
  logic              mismatch;

  assign exp_sel  = expected[check_slot];
  assign slot_inc = {1'b0, check_slot} + (SLOT_W+1)'(1);
  assign mismatch = (reg_readback != exp_sel);
  assign wait_cur = mismatch ? WAIT_TICKS : recovery_wait;

  always_comb begin
    chk.mismatch        = mismatch;
    chk.wait_active     = (wait_cur != '0);
    chk.rewrite_request = mismatch && (check_slot != IDENTITY_SLOT);
    chk.rewrite_slot    = chk.rewrite_request ? check_slot : '0;
    chk.rewrite_value   = chk.rewrite_request ? exp_sel : '0;
    chk.next_slot       = (slot_inc >= (SLOT_W+1)'(NUM_SLOTS)) ? '0 : slot_inc[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        expected[i] <= EXPECTED_RESET[i];
      end
    end else if (cfg_we) begin
      expected[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_slot    <= '0;
      recovery_wait <= '0;
    end else if (advance) begin
      check_slot    <= chk.next_slot;
      recovery_wait <= chk.wait_active ? wait_cur - WAIT_W'(1) : '0;
    end
  end

endmodule

FILE: rtl/accel_sample_health_monitor.sv
// Top level of the accel sample health monitor: lanes, merge and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | reg_readback, accel_status, accel_x/y/z
//  out      | out_valid / out_stall| sample_status, out_x/y/z, error_total, rewrite_*,
//           |                      | next_slot
//  cfg      | cfg_we               | cfg_index, cfg_data (expected register values)
//
// One item per cycle sustained while out_stall is low. A result appears in the output
// register in the cycle after its item is accepted; the single compare/count stage sets that.
// in_stall is high only while the output register holds a result that is stalled.
// rst is synchronous: it clears slot, wait, run count, last samples and error total,
// and loads the expected register values with their defaults.
`include "accel_sample_health_monitor_macros.svh"

module accel_sample_health_monitor
  import ashm_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [SLOT_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CFG_W-1:0]          reg_readback,
  input  logic [7:0]                accel_status,
  input  logic signed [AXIS_W-1:0]  accel_x,
  input  logic signed [AXIS_W-1:0]  accel_y,
  input  logic signed [AXIS_W-1:0]  accel_z,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                sample_status,
  output logic signed [AXIS_W-1:0]  out_x,
  output logic signed [AXIS_W-1:0]  out_y,
  output logic signed [AXIS_W-1:0]  out_z,
  output logic [TOTAL_W-1:0]        error_total,
  output logic                      rewrite_request,
  output logic [SLOT_W-1:0]         rewrite_slot,
  output logic [CFG_W-1:0]          rewrite_value,
  output logic [SLOT_W-1:0]         next_slot
);

  logic                     accept;
  chk_t                     chk;
  logic signed [AXIS_W-1:0] axis_in [NUM_AXES];
  logic [NUM_AXES-1:0]      lane_match;
  logic                     lane_load;

  logic [RUN_W-1:0]         run_count;
  logic [RUN_W-1:0]         run_inc;
  logic                     new_data;
  logic                     stuck;
  logic                     sample_path;
  logic                     error_event;
  logic [TOTAL_W-1:0]       total_acc;
  logic [TOTAL_W-1:0]       total_next;
  sample_status_t           status_next;

  // Hold the input while a finished result sits stalled in the output register.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  ashm_reg_check #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_reg_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .reg_readback (reg_readback),
    .advance      (accept),
    .chk          (chk)
  );

  // Axis lanes: each compares its axis against the last published sample.
  assign axis_in[0] = accel_x;
  assign axis_in[1] = accel_y;
  assign axis_in[2] = accel_z;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    ashm_axis_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .sample (axis_in[g]),
      .load   (lane_load),
      .match  (lane_match[g])
    );
  end

  // Merge: the sample repeats only if every lane matched.
  assign new_data    = accel_status[NEW_XYZ_BIT];
  assign sample_path = !chk.wait_active && new_data;
  assign run_inc     = (&lane_match) ? run_count + RUN_W'(1) : '0;
  assign stuck       = (run_inc > STUCK_LIMIT);
  assign lane_load   = accept && sample_path && !stuck;

  // Register errors and stuck faults never coincide: a mismatch forces the wait.
  assign error_event = chk.mismatch || (sample_path && stuck);
  assign total_next  = (error_event && (total_acc != '1)) ? total_acc + TOTAL_W'(1)
                                                         : total_acc;

  always_comb begin
    if (chk.wait_active) begin
      status_next = ST_WAIT;
    end else if (!new_data) begin
      status_next = ST_NO_DATA;
    end else if (stuck) begin
      status_next = ST_STUCK;
    end else begin
      status_next = ST_PUBLISH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      total_acc <= '0;
    end else if (accept) begin
      total_acc <= total_next;
      if (sample_path) begin
        run_count <= stuck ? '0 : run_inc;
      end
    end
  end

  // Result register: advance on accept, drop the valid once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_status   <= status_next;
      out_x           <= (status_next == ST_PUBLISH) ? accel_x : '0;
      out_y           <= (status_next == ST_PUBLISH) ? accel_y : '0;
      out_z           <= (status_next == ST_PUBLISH) ? accel_z : '0;
      error_total     <= total_next;
      rewrite_request <= chk.rewrite_request;
      rewrite_slot    <= chk.rewrite_slot;
      rewrite_value   <= chk.rewrite_value;
      next_slot       <= chk.next_slot;
    end
  end

  // A rewrite comes only from a register error, which always starts the wait.
  `ASHM_ASSERT(a_rewrite_in_wait, clk, rst,
               out_valid && rewrite_request |-> sample_status == ST_WAIT)
  // Unpublished results carry a zero sample.
  `ASHM_ASSERT(a_unpublished_zero, clk, rst,
               out_valid && sample_status != ST_PUBLISH |-> (out_x | out_y | out_z) == '0)
  // The run count is cleared before it can pass the stuck limit.
  `ASHM_ASSERT_ALWAYS(a_run_bounded, clk, rst || (run_count <= STUCK_LIMIT))
  // An output slot never points past the last checked slot.
  `ASHM_ASSERT(a_slot_range, clk, rst, out_valid |-> 32'(next_slot) < NUM_SLOTS)

endmodule
